// ===== rtl/dsc_pkg.sv =====
// Package: shared types, codes and constants of the DMX slot capture receiver.
`default_nettype none

package dsc_pkg;

   // Default number of captured channels and the most results one fetch may give.
   localparam int DEF_CHANNELS = 16;
   localparam int MAX_RESULTS  = 16;

   // Field widths of the channels.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int ADDR_W      = 10;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 8;
   localparam int KIND_W      = 2;
   localparam int INDEX_W     = 4;
   localparam int SLOT_W      = 9;
   localparam int RLEN_W      = 5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_CODE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_CODE  = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [ADDR_W-1:0] START_ADDRESS_RST = 10'd1;
   localparam logic [BYTE_W-1:0] DISPLAY_CODE_RST  = 8'd0;
   localparam logic [BYTE_W-1:0] CONTROL_CODE_RST  = 8'd1;

   // Opcodes of an input item.
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Frame kinds reported by a fetch.
   typedef enum logic [KIND_W-1:0] {
      KIND_NONE    = 2'd0,
      KIND_DISPLAY = 2'd1,
      KIND_CONTROL = 2'd2
   } frame_kind_type;

   // Progress through a received frame.
   typedef enum logic [1:0] {
      FS_BREAK = 2'd0,
      FS_CODE  = 2'd1,
      FS_DATA  = 2'd2,
      FS_IDLE  = 2'd3
   } frame_stage_type;

   // Controller states.
   typedef enum logic [1:0] {
      CS_IDLE   = 2'd0,
      CS_SINGLE = 2'd1,
      CS_LOAD   = 2'd2,
      CS_SEND   = 2'd3
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic byte_take;
      logic fetch_take;
      logic emit_single;
      logic emit_chan;
   } dsc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fetch_single;
      logic out_free;
      logic last_chan;
   } dsc_stat_type;

endpackage

`default_nettype wire

// ===== rtl/dsc_if.sv =====
// Interfaces: request, response and register write channels.
`default_nettype none

interface dsc_req_if import dsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [BYTE_W-1:0] rx_byte;
   logic              framing_error;
   logic [LEN_W-1:0]  fetch_length;

   modport source (output valid, output opcode, output rx_byte, output framing_error,
                   output fetch_length, input ready);
   modport sink   (input valid, input opcode, input rx_byte, input framing_error,
                   input fetch_length, output ready);
endinterface

interface dsc_rsp_if import dsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  frame_kind;
   logic [INDEX_W-1:0] channel_index;
   logic [BYTE_W-1:0]  channel_value;
   logic               last;

   modport source (output valid, output frame_kind, output channel_index,
                   output channel_value, output last, input ready);
   modport sink   (input valid, input frame_kind, input channel_index,
                   input channel_value, input last, output ready);
endinterface

interface dsc_csr_if import dsc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmx_slot_capture_receiver.sv =====
// Top level: DMX slot capture receiver, controller plus datapath.
//
//   Channel   Role     Carries                                            Width
//   req_bus   sink     opcode, rx_byte, framing_error, fetch_length       1/8/1/8
//   rsp_bus   source   frame_kind, channel_index, channel_value, last     2/4/8/1
//   csr_bus   sink     index (0 start_address, 1 display_code,            2/10
//                      2 control_code), data
//
// A received byte is taken while idle, and the next item is accepted on the next cycle.
// A fetch that gives one result passes through the single state; a fetch that streams N channels
// waits in the load state for the channel store read, then sends one result per cycle unless stalled.
// Reset is synchronous; the channel store is not cleared, as no frame is complete before
// every channel has been written. A stalled response holds the controller, and the next
// request is accepted once the last result of a fetch sits in the response register.
`default_nettype none

module dmx_slot_capture_receiver import dsc_pkg::*; #(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input wire logic clock,
   input wire logic reset,
   dsc_req_if.sink   req_bus,
   dsc_rsp_if.source rsp_bus,
   dsc_csr_if.sink   csr_bus
);

   dsc_cmd_type  cmd;
   dsc_stat_type stat;

   // Register writes are always taken; user must write only while the block is idle, unchecked.
   assign csr_bus.ready = 1'b1;

   // The controller owns the request handshake and walks each fetch through its results.
   dsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath parses frames, keeps the captured channels and drives each transfer
   // of the response channel from its output register.
   dsc_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_bus.rx_byte),
      .req_framing_error (req_bus.framing_error),
      .req_fetch_length  (req_bus.fetch_length),
      .csr_write         (csr_bus.valid && csr_bus.ready),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_frame_kind    (rsp_bus.frame_kind),
      .rsp_channel_index (rsp_bus.channel_index),
      .rsp_channel_value (rsp_bus.channel_value),
      .rsp_last          (rsp_bus.last),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

`default_nettype wire

// ===== rtl/dsc_ram.sv =====
// Generic single-port-write, one-read-port RAM with registered read data.
`default_nettype none

module dsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/dsc_ctrl.sv =====
// Controller: sequences byte intake, single-result fetches and channel streaming.
`default_nettype none

module dsc_ctrl import dsc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_opcode,
   output logic              req_ready,
   input  wire dsc_stat_type stat,
   output dsc_cmd_type       cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_FETCH) begin
                  cmd.fetch_take = 1'b1;
                  state_in       = stat.fetch_single ? CS_SINGLE : CS_LOAD;
               end else begin
                  cmd.byte_take = 1'b1;
               end
            end
         end
         CS_SINGLE: begin
            if (stat.out_free) begin
               cmd.emit_single = 1'b1;
               state_in        = CS_IDLE;
            end
         end
         CS_LOAD: begin
            // The first channel read is in flight.
            state_in = CS_SEND;
         end
         CS_SEND: begin
            if (stat.out_free) begin
               cmd.emit_chan = 1'b1;
               if (stat.last_chan) begin
                  state_in = CS_IDLE;
               end
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/dsc_datapath.sv =====
// Datapath: registers, frame parser, channel store and response register.
`default_nettype none

module dsc_datapath import dsc_pkg::*; #(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [BYTE_W-1:0]      req_rx_byte,
   input  wire logic                   req_framing_error,
   input  wire logic [LEN_W-1:0]       req_fetch_length,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [KIND_W-1:0]      rsp_frame_kind,
   output logic      [INDEX_W-1:0]     rsp_channel_index,
   output logic      [BYTE_W-1:0]      rsp_channel_value,
   output logic                        rsp_last,
   input  wire dsc_cmd_type            cmd,
   output dsc_stat_type                stat
);

   localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CCW      = $clog2(CHANNELS + 1);
   localparam int MaxFetch = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;
   localparam logic [CCW-1:0]   ChanCount = CCW'(CHANNELS);
   localparam logic [LEN_W:0]   MaxLen    = (LEN_W + 1)'(MaxFetch);

   // Configuration.
   logic [ADDR_W-1:0] start_addr_ff, start_addr_in;
   logic [BYTE_W-1:0] disp_code_ff, disp_code_in;
   logic [BYTE_W-1:0] ctrl_code_ff, ctrl_code_in;

   // Frame reception.
   frame_stage_type   stage_ff, stage_in;
   logic [SLOT_W-1:0] skip_ff, skip_in;
   logic [CCW-1:0]    cap_ff, cap_in;
   logic [SLOT_W-1:0] offset_ff, offset_in;
   logic [BYTE_W-1:0] code_ff, code_in;
   logic              ready_ff, ready_in;
   logic              rx_en_ff, rx_en_in;

   // Fetch streaming.
   frame_kind_type     kind_ff, kind_in;
   logic [RLEN_W-1:0]  len_ff, len_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [BYTE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   // Helpers.
   frame_stage_type    stage_eff;
   logic [SLOT_W-1:0]  skip_eff;
   logic [CCW-1:0]     cap_eff;
   logic [SLOT_W-1:0]  addr_offset;
   frame_kind_type     kind_now;
   logic               too_long;
   logic               last_chan;
   logic               out_free;
   logic [INDEX_W-1:0] rd_idx;
   logic               wr_en;
   logic [BYTE_W-1:0]  rd_data;

   dsc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CHANNELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(cap_eff)),
      .wr_data (req_rx_byte),
      .rd_addr (AW'(rd_idx)),
      .rd_data (rd_data)
   );

   // Slot offset of a display frame; out-of-range addresses clamp.
   always_comb begin
      if (start_addr_ff == '0) begin
         addr_offset = '0;
      end else if (start_addr_ff > 10'd512) begin
         addr_offset = 9'd511;
      end else begin
         addr_offset = SLOT_W'(start_addr_ff - 10'd1);
      end
   end

   always_comb begin
      kind_now = KIND_NONE;
      if (ready_ff) begin
         if (code_ff == disp_code_ff) begin
            kind_now = KIND_DISPLAY;
         end else if (code_ff == ctrl_code_ff) begin
            kind_now = KIND_CONTROL;
         end
      end
   end

   assign too_long  = {1'b0, req_fetch_length} > MaxLen;
   assign last_chan = (RLEN_W'(idx_ff) + RLEN_W'(1)) == len_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_idx    = (cmd.emit_chan && !last_chan) ? INDEX_W'(idx_ff + 4'd1) : idx_ff;

   assign stat.fetch_single = too_long || (kind_now == KIND_NONE) || (req_fetch_length == '0);
   assign stat.out_free     = out_free;
   assign stat.last_chan    = last_chan;

   always_comb begin
      start_addr_in = start_addr_ff;
      disp_code_in  = disp_code_ff;
      ctrl_code_in  = ctrl_code_ff;
      stage_in      = stage_ff;
      skip_in       = skip_ff;
      cap_in        = cap_ff;
      offset_in     = offset_ff;
      code_in       = code_ff;
      ready_in      = ready_ff;
      rx_en_in      = rx_en_ff;
      kind_in       = kind_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;

      stage_eff = req_framing_error ? FS_BREAK : stage_ff;
      skip_eff  = req_framing_error ? '0 : skip_ff;
      cap_eff   = req_framing_error ? '0 : cap_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_START_ADDRESS: start_addr_in = csr_data;
            CSR_DISPLAY_CODE:  disp_code_in  = BYTE_W'(csr_data);
            CSR_CONTROL_CODE:  ctrl_code_in  = BYTE_W'(csr_data);
            default: ;
         endcase
      end

      if (cmd.byte_take && rx_en_ff) begin
         skip_in = skip_eff;
         cap_in  = cap_eff;
         unique case (stage_eff)
            FS_BREAK: stage_in = FS_CODE;
            FS_CODE: begin
               if ((req_rx_byte == disp_code_ff) || (req_rx_byte == ctrl_code_ff)) begin
                  offset_in = (req_rx_byte == disp_code_ff) ? addr_offset : '0;
                  code_in   = req_rx_byte;
                  stage_in  = FS_DATA;
               end else begin
                  stage_in = FS_IDLE;
               end
            end
            FS_DATA: begin
               if (skip_eff >= offset_ff) begin
                  if (cap_eff < ChanCount) begin
                     wr_en  = 1'b1;
                     cap_in = CCW'(cap_eff + 1'b1);
                  end
                  if (cap_in >= ChanCount) begin
                     rx_en_in = 1'b0;
                     ready_in = 1'b1;
                     stage_in = FS_IDLE;
                  end
               end else begin
                  skip_in = SLOT_W'(skip_eff + 1'b1);
               end
            end
            FS_IDLE: ;
            default: ;
         endcase
      end

      if (cmd.fetch_take) begin
         idx_in  = '0;
         len_in  = RLEN_W'(req_fetch_length);
         kind_in = too_long ? KIND_NONE : kind_now;
         if (!too_long) begin
            ready_in = 1'b0;
            rx_en_in = 1'b1;
         end
      end

      if (cmd.emit_single) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind_ff;
         rsp_index_in = '0;
         rsp_value_in = '0;
         rsp_last_in  = 1'b1;
      end

      if (cmd.emit_chan) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind_ff;
         rsp_index_in = idx_ff;
         rsp_value_in = rd_data;
         rsp_last_in  = last_chan;
         idx_in       = INDEX_W'(idx_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_addr_ff <= START_ADDRESS_RST;
         disp_code_ff  <= DISPLAY_CODE_RST;
         ctrl_code_ff  <= CONTROL_CODE_RST;
         stage_ff      <= FS_IDLE;
         skip_ff       <= '0;
         cap_ff        <= '0;
         offset_ff     <= '0;
         code_ff       <= '0;
         ready_ff      <= 1'b0;
         rx_en_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_addr_ff <= start_addr_in;
         disp_code_ff  <= disp_code_in;
         ctrl_code_ff  <= ctrl_code_in;
         stage_ff      <= stage_in;
         skip_ff       <= skip_in;
         cap_ff        <= cap_in;
         offset_ff     <= offset_in;
         code_ff       <= code_in;
         ready_ff      <= ready_in;
         rx_en_ff      <= rx_en_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_kind    = rsp_kind_ff;
   assign rsp_channel_index = rsp_index_ff;
   assign rsp_channel_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/dsc_checker.sv =====
// Checker: port-level properties of the receiver, bound to the top level.
`default_nettype none

module dsc_checker import dsc_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [KIND_W-1:0]  frame_kind,
   input wire logic [INDEX_W-1:0] channel_index,
   input wire logic [BYTE_W-1:0]  channel_value,
   input wire logic               last
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A result without new data is a lone, empty final result.
   a_none_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (frame_kind == KIND_NONE) |->
      last && (channel_index == '0) && (channel_value == '0))
      else $error("no-data result is not a lone empty result");

   // Within a stream the next channel follows at once with the next index and same kind.
   a_stream_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last |=>
      rsp_valid && (channel_index == INDEX_W'($past(channel_index) + 4'd1)) &&
      (frame_kind == $past(frame_kind)))
      else $error("stream broke its channel sequence");

   // No request is taken while a stream is still being delivered.
   a_no_req_mid_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last |-> !req_ready)
      else $error("request accepted during a stream");

endmodule

bind dmx_slot_capture_receiver dsc_checker u_dsc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .frame_kind    (rsp_bus.frame_kind),
   .channel_index (rsp_bus.channel_index),
   .channel_value (rsp_bus.channel_value),
   .last          (rsp_bus.last)
);

`default_nettype wire
